### design/hrbp_pkg.sv
// shared types, codes and lookup functions for the http request byte parser
`default_nettype none

package hrbp_pkg;

    // width of the content length accumulator and body counter (8 to 32)
    localparam int LENGTH_WIDTH = 32;
    // width of the content_length result field
    localparam int CL_WIDTH     = 32;
    localparam int NAME_LEN     = 14;
    localparam int GET_LEN      = 3;

    typedef logic [LENGTH_WIDTH-1:0] t_len;

    typedef enum logic [3:0] {
        PH_RL_START,
        PH_RL_METHOD,
        PH_RL_URL,
        PH_RL_VERSION,
        PH_RL_END,
        PH_RL_ERROR,
        PH_HD_START,
        PH_HD_KEY,
        PH_HD_VALUE,
        PH_HD_NEXT,
        PH_HD_LINE_END,
        PH_HD_END,
        PH_HD_ERROR,
        PH_BODY
    } t_phase;

    typedef enum logic [2:0] {
        TAG_SKIP,
        TAG_METHOD,
        TAG_URL,
        TAG_VERSION,
        TAG_NAME,
        TAG_VALUE,
        TAG_BODY
    } t_tag;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD,
        ST_INCOMPLETE
    } t_status;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_CLOSE = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]          byte_out;
        t_tag                tag;
        logic                header_done;
        logic                request_done;
        t_status             status;
        logic                is_get;
        logic [CL_WIDTH-1:0] content_length;
    } t_result;

    // letters of "get"
    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = "g";
            2'd1:    ch = "e";
            2'd2:    ch = "t";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // letters of "content-length"
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // upper case ascii letters to lower case, everything else untouched
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= "A" && b <= "Z") begin
            r = b | 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/hrbp_in_if.sv
// request byte channel: valid/ready with action and byte payload
`default_nettype none

interface hrbp_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_value;

    modport source (output valid, output action, output byte_value, input ready);
    modport sink   (input valid, input action, input byte_value, output ready);
endinterface

`default_nettype wire

### design/hrbp_out_if.sv
// parse result channel: valid/ready with tagged byte and completion info
`default_nettype none

interface hrbp_out_if;
    import hrbp_pkg::*;

    logic                valid;
    logic                ready;
    logic [7:0]          byte_out;
    logic [2:0]          tag;
    logic                header_done;
    logic                request_done;
    logic [1:0]          status;
    logic                is_get;
    logic [CL_WIDTH-1:0] content_length;

    modport source (
        output valid, output byte_out, output tag, output header_done,
        output request_done, output status, output is_get, output content_length,
        input  ready
    );
    modport sink (
        input  valid, input byte_out, input tag, input header_done,
        input  request_done, input status, input is_get, input content_length,
        output ready
    );
endinterface

`default_nettype wire

### design/hrbp_engine.sv
// parser state machine: request line, headers, length parse and body count
`default_nettype none

module hrbp_engine (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  hrbp_pkg::t_in_item  i_item,
    output hrbp_pkg::t_result   o_result
);
    import hrbp_pkg::*;

    localparam t_len LEN_MAX = {LENGTH_WIDTH{1'b1}};

    t_phase     r_phase,         n_phase;
    logic [1:0] r_method_pos,    n_method_pos;
    logic       r_method_get,    n_method_get;
    logic [3:0] r_name_pos,      n_name_pos;
    logic       r_name_match,    n_name_match;
    logic       r_value_started, n_value_started;
    logic       r_digits_closed, n_digits_closed;
    t_len       r_length_accum,  n_length_accum;
    t_len       r_length_value,  n_length_value;
    t_len       r_body_rem,      n_body_rem;

    logic [7:0]              c;
    logic [7:0]              raw;
    logic                    letter;
    logic                    digit;
    logic                    method_hit;
    logic                    name_hit;
    logic [LENGTH_WIDTH+3:0] accum_x10;
    t_len                    rem_dec;
    logic                    do_finish;
    logic                    clear_ln;
    t_status                 fin_status;
    t_result                 res;

    always_comb begin
        raw        = i_item.byte_value;
        c          = fold_case(raw);
        letter     = (c >= "a") && (c <= "z");
        digit      = (c >= "0") && (c <= "9");
        method_hit = (r_method_pos < 2'(GET_LEN)) && (c == get_char(r_method_pos));
        name_hit   = (r_name_pos < 4'(NAME_LEN)) && (c == name_char(r_name_pos));
        // accum * 10 + digit, kept four bits wider to see the overflow
        accum_x10  = ({4'b0, r_length_accum} << 3) + ({4'b0, r_length_accum} << 1)
                   + (LENGTH_WIDTH+4)'(c[3:0]);
        rem_dec    = (r_body_rem != '0) ? r_body_rem - t_len'(1) : r_body_rem;

        n_phase         = r_phase;
        n_method_pos    = r_method_pos;
        n_method_get    = r_method_get;
        n_name_pos      = r_name_pos;
        n_name_match    = r_name_match;
        n_value_started = r_value_started;
        n_digits_closed = r_digits_closed;
        n_length_accum  = r_length_accum;
        n_length_value  = r_length_value;
        n_body_rem      = r_body_rem;

        res        = '0;
        res.tag    = TAG_SKIP;
        res.status = ST_OK;
        do_finish  = 1'b0;
        clear_ln   = 1'b0;
        fin_status = ST_OK;

        if (i_item.action == ACT_CLOSE) begin
            do_finish  = 1'b1;
            fin_status = (r_phase <= PH_RL_ERROR) ? ST_INCOMPLETE : ST_OK;
        end else if (r_phase == PH_BODY) begin
            // body bytes pass unfolded
            res.byte_out = raw;
            res.tag      = TAG_BODY;
            n_body_rem   = rem_dec;
            if (rem_dec == '0) begin
                do_finish = 1'b1;
            end
        end else begin
            res.byte_out = c;
            unique case (r_phase)
                PH_RL_START, PH_RL_METHOD: begin
                    if (letter) begin
                        res.tag = TAG_METHOD;
                        if (method_hit) begin
                            n_method_pos = r_method_pos + 2'd1;
                        end else begin
                            n_method_get = 1'b0;
                        end
                        n_phase = PH_RL_METHOD;
                    end else if (c == CH_SPACE) begin
                        if (r_phase == PH_RL_METHOD) begin
                            n_phase = PH_RL_URL;
                        end
                    end else if (r_phase == PH_RL_START) begin
                        n_phase = PH_RL_ERROR;
                    end
                end
                PH_RL_URL: begin
                    if (c != CH_SPACE) begin
                        res.tag = TAG_URL;
                    end else begin
                        n_phase = PH_RL_VERSION;
                    end
                end
                PH_RL_VERSION: begin
                    if (c != CH_CR) begin
                        res.tag = TAG_VERSION;
                    end else begin
                        n_phase = PH_RL_END;
                    end
                end
                PH_RL_END: begin
                    if (c == CH_LF) begin
                        clear_ln = 1'b1;
                        n_phase  = PH_HD_START;
                    end else begin
                        do_finish  = 1'b1;
                        fin_status = ST_BAD;
                    end
                end
                PH_HD_START, PH_HD_LINE_END: begin
                    if (letter) begin
                        res.tag = TAG_NAME;
                        if (name_hit) begin
                            n_name_pos = r_name_pos + 4'd1;
                        end else begin
                            n_name_match = 1'b0;
                        end
                        n_phase = PH_HD_KEY;
                    end else if (c == CH_CR && r_phase == PH_HD_LINE_END) begin
                        n_phase = PH_HD_END;
                    end else begin
                        n_phase = PH_HD_ERROR;
                    end
                end
                PH_HD_KEY: begin
                    if (c != CH_COLON) begin
                        res.tag = TAG_NAME;
                        if (name_hit) begin
                            n_name_pos = r_name_pos + 4'd1;
                        end else begin
                            n_name_match = 1'b0;
                        end
                    end else begin
                        n_phase = PH_HD_VALUE;
                    end
                end
                PH_HD_VALUE: begin
                    if (c == CH_CR) begin
                        n_phase = PH_HD_NEXT;
                    end else if (!r_value_started && c == CH_SPACE) begin
                        // leading space dropped
                    end else begin
                        n_value_started = 1'b1;
                        res.tag         = TAG_VALUE;
                        if (!r_digits_closed && digit) begin
                            if (accum_x10 > {4'b0, LEN_MAX}) begin
                                n_length_accum = LEN_MAX;
                            end else begin
                                n_length_accum = accum_x10[LENGTH_WIDTH-1:0];
                            end
                        end else begin
                            n_digits_closed = 1'b1;
                        end
                    end
                end
                PH_HD_NEXT: begin
                    if (c == CH_LF) begin
                        res.header_done = 1'b1;
                        if (r_name_match && r_name_pos == 4'(NAME_LEN)) begin
                            n_length_value = r_length_accum;
                        end
                        clear_ln = 1'b1;
                        n_phase  = PH_HD_LINE_END;
                    end else begin
                        n_phase = PH_HD_ERROR;
                    end
                end
                PH_HD_END: begin
                    if (c == CH_LF) begin
                        if (r_length_value == '0) begin
                            do_finish = 1'b1;
                        end else begin
                            n_body_rem = r_length_value;
                            n_phase    = PH_BODY;
                        end
                    end else begin
                        do_finish  = 1'b1;
                        fin_status = ST_BAD;
                    end
                end
                default: begin
                    // error phases: the byte after the bad one ends the request
                    do_finish  = 1'b1;
                    fin_status = ST_BAD;
                end
            endcase
        end

        if (clear_ln) begin
            n_name_pos      = '0;
            n_name_match    = 1'b1;
            n_value_started = 1'b0;
            n_length_accum  = '0;
            n_digits_closed = 1'b0;
        end

        if (do_finish) begin
            res.request_done = 1'b1;
            res.status       = fin_status;
            if (fin_status == ST_OK) begin
                res.is_get         = r_method_get && (r_method_pos == 2'(GET_LEN));
                res.content_length = CL_WIDTH'(r_length_value);
            end
            n_phase         = PH_RL_START;
            n_method_pos    = '0;
            n_method_get    = 1'b1;
            n_name_pos      = '0;
            n_name_match    = 1'b1;
            n_value_started = 1'b0;
            n_digits_closed = 1'b0;
            n_length_accum  = '0;
            n_length_value  = '0;
            n_body_rem      = '0;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_RL_START;
            r_method_pos    <= '0;
            r_method_get    <= 1'b1;
            r_name_pos      <= '0;
            r_name_match    <= 1'b1;
            r_value_started <= 1'b0;
            r_digits_closed <= 1'b0;
            r_length_accum  <= '0;
            r_length_value  <= '0;
            r_body_rem      <= '0;
        end else if (i_fire) begin
            r_phase         <= n_phase;
            r_method_pos    <= n_method_pos;
            r_method_get    <= n_method_get;
            r_name_pos      <= n_name_pos;
            r_name_match    <= n_name_match;
            r_value_started <= n_value_started;
            r_digits_closed <= n_digits_closed;
            r_length_accum  <= n_length_accum;
            r_length_value  <= n_length_value;
            r_body_rem      <= n_body_rem;
        end
    end

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_body_rem != '0)
        else $error("body phase with nothing left to count");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !res.request_done |-> (res.status == ST_OK && res.content_length == '0))
        else $error("status or length shown without request end");

    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.request_done |=> r_phase == PH_RL_START && r_length_value == '0)
        else $error("parser did not return to request line start");

    a_name_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_pos <= 4'(NAME_LEN))
        else $error("header name match position ran past the name");

endmodule

`default_nettype wire

### design/http_request_byte_parser.sv
// top level of the http request byte parser with input and result registers
//
// Streaming HTTP/1.0 request parser. Each transfer on i_req carries one
// received byte (action 0) or a connection-closed event (action 1), and each
// gives exactly one transfer on o_res: the byte folded to lower case (body
// bytes unchanged, 0 for a close), a tag saying which part of the request it
// belongs to, header_done on the line feed that completes a header line, and
// request_done with a status on the item that ends the request. is_get and
// content_length are only meaningful with request_done and status ok. A bad
// byte is flagged as bad request on the byte after it, or on itself where a
// line feed must follow a carriage return; a close before the request line
// is complete reports an incomplete request line. Items pass through the
// input register and the parse logic into the result register. The block
// sustains one transfer per clock in both directions while o_res is ready;
// its parser state machine sets the rate, updating its state once per byte.
`default_nettype none

module http_request_byte_parser (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hrbp_in_if.sink    i_req,
    hrbp_out_if.source o_res
);
    import hrbp_pkg::*;

    // input register stage
    logic     r_in_valid;
    t_in_item r_in;
    // result register stage
    logic     r_out_valid;
    t_result  r_out;

    logic     fire;     // item moves from input register through the parser
    logic     in_take;  // transfer on i_req
    t_result  step_res;

    // the parser step happens when the result register is free or draining
    assign fire    = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_take = i_req.valid && i_req.ready;

    // input register may refill in the same cycle its item moves on
    assign i_req.ready = !r_in_valid || fire;

    hrbp_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.action     <= i_req.action;
            r_in.byte_value <= i_req.byte_value;
        end
        if (fire) begin
            r_out <= step_res;
        end
    end

    // result channel drive
    assign o_res.valid          = r_out_valid;
    assign o_res.byte_out       = r_out.byte_out;
    assign o_res.tag            = r_out.tag;
    assign o_res.header_done    = r_out.header_done;
    assign o_res.request_done   = r_out.request_done;
    assign o_res.status         = r_out.status;
    assign o_res.is_get         = r_out.is_get;
    assign o_res.content_length = r_out.content_length;

    // a held result must not be overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !fire)
        else $error("result register overwritten while stalled");

    // an accepted item reaches the parser no later than a free result slot allows
    a_in_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |-> fire)
        else $error("input register stalled with a free result register");

    // every parser step leaves a valid result behind
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("parser step produced no result");

endmodule

`default_nettype wire
